>>> rtl/pps_pkg.sv
package pps_pkg;

    localparam int PRIO_W = 8;
    localparam int SLOT_W = 4;
    localparam int FIELD_W = 16;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_RAN  = 2'd1,
        KIND_IDLE = 2'd2
    } t_kind;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic load;   // write the addressed slot
        logic run;    // take one tick of work from the addressed slot
    } t_cell_cmd;

endpackage

>>> rtl/pps_cell.sv
module pps_cell #(
    parameter int TIME_BITS = 16,
    parameter int IW        = 4,
    parameter int CELL_IDX  = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pps_pkg::t_cell_cmd          i_cmd,
    input  logic [IW-1:0]               i_idx,
    input  logic [TIME_BITS-1:0]        i_arrival,
    input  logic [TIME_BITS-1:0]        i_burst,
    input  logic [pps_pkg::PRIO_W-1:0]  i_prio,
    input  logic [TIME_BITS-1:0]        i_now,
    input  logic                        i_cand_vld,
    input  logic [pps_pkg::PRIO_W-1:0]  i_cand_prio,
    input  logic [IW-1:0]               i_cand_idx,
    input  logic [TIME_BITS-1:0]        i_cand_arrival,
    input  logic [TIME_BITS-1:0]        i_cand_burst,
    input  logic                        i_cand_last,
    output logic                        o_cand_vld,
    output logic [pps_pkg::PRIO_W-1:0]  o_cand_prio,
    output logic [IW-1:0]               o_cand_idx,
    output logic [TIME_BITS-1:0]        o_cand_arrival,
    output logic [TIME_BITS-1:0]        o_cand_burst,
    output logic                        o_cand_last
);
    import pps_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    logic                 r_valid;
    logic [TIME_BITS-1:0] r_arrival;
    logic [TIME_BITS-1:0] r_burst;
    logic [PRIO_W-1:0]    r_prio;
    logic [TIME_BITS-1:0] r_remain;

    logic w_sel;
    logic w_ready;
    logic w_win;

    assign w_sel   = (i_idx == MY_IDX);
    assign w_ready = r_valid && (r_arrival <= i_now) && (r_remain != '0);
    // strict less: on equal priority the lower slot upstream keeps it
    assign w_win   = w_ready && (!i_cand_vld || (r_prio < i_cand_prio));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            o_cand_vld <= 1'b0;
        end else begin
            if (i_cmd.load && w_sel) begin
                r_valid <= 1'b1;
            end else if (i_cmd.run && w_sel && (r_remain == TIME_BITS'(1))) begin
                r_valid <= 1'b0;
            end
            o_cand_vld <= w_win || i_cand_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_sel) begin
            r_arrival <= i_arrival;
            r_burst   <= i_burst;
            r_prio    <= i_prio;
            r_remain  <= i_burst;
        end else if (i_cmd.run && w_sel) begin
            r_remain  <= r_remain - 1'b1;
        end
        if (w_win) begin
            o_cand_prio    <= r_prio;
            o_cand_idx     <= MY_IDX;
            o_cand_arrival <= r_arrival;
            o_cand_burst   <= r_burst;
            o_cand_last    <= (r_remain == TIME_BITS'(1));
        end else begin
            o_cand_prio    <= i_cand_prio;
            o_cand_idx     <= i_cand_idx;
            o_cand_arrival <= i_cand_arrival;
            o_cand_burst   <= i_cand_burst;
            o_cand_last    <= i_cand_last;
        end
    end

endmodule

>>> rtl/preemptive_priority_scheduler_core.sv
// Preemptive priority scheduler over MAX_PROCS process slots, one cell per
// slot in a chain. A load transfer writes a slot; its result moves to the
// output register in the emit state once that register is free, and the
// next transfer is taken only after that. A tick first runs the
// best-candidate pass that ripples one cell per cycle down the chain; then
// the winner is charged a tick, the clock advances and the result goes out
// through the emit state in the same way. One item is worked on at a time;
// a finished result sits in the output register while the next transfer is
// taken. Ties on priority go to the lowest slot, loads to slots beyond the
// table are answered but change nothing, and the clock saturates at its
// all-ones value.
module preemptive_priority_scheduler_core #(
    parameter int MAX_PROCS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_action,
    input  logic [pps_pkg::SLOT_W-1:0]    i_slot,
    input  logic [pps_pkg::FIELD_W-1:0]   i_arrival,
    input  logic [pps_pkg::FIELD_W-1:0]   i_burst,
    input  logic [pps_pkg::PRIO_W-1:0]    i_prio,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_kind,
    output logic [pps_pkg::SLOT_W-1:0]    o_ran_slot,
    output logic                          o_finished,
    output logic [pps_pkg::FIELD_W-1:0]   o_completion,
    output logic [pps_pkg::FIELD_W-1:0]   o_turnaround,
    output logic [pps_pkg::FIELD_W-1:0]   o_waiting
);
    import pps_pkg::*;

    localparam int IW   = $clog2(MAX_PROCS);
    localparam int CW   = $clog2(MAX_PROCS + 1);
    localparam int LAST = MAX_PROCS - 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    t_state               r_state;
    logic [CW-1:0]        r_cnt;
    logic [TIME_BITS-1:0] r_now;

    // result waiting for the output register
    t_kind                r_p_kind;
    logic [SLOT_W-1:0]    r_p_slot;
    logic                 r_p_fin;
    logic [FIELD_W-1:0]   r_p_comp;
    logic [FIELD_W-1:0]   r_p_tat;
    logic [FIELD_W-1:0]   r_p_wt;

    // candidate chain, entry k is the registered output of cell k
    logic                 c_vld  [MAX_PROCS];
    logic [PRIO_W-1:0]    c_prio [MAX_PROCS];
    logic [IW-1:0]        c_idx  [MAX_PROCS];
    logic [TIME_BITS-1:0] c_arr  [MAX_PROCS];
    logic [TIME_BITS-1:0] c_bur  [MAX_PROCS];
    logic                 c_last [MAX_PROCS];

    logic                 a_vld  [MAX_PROCS];
    logic [PRIO_W-1:0]    a_prio [MAX_PROCS];
    logic [IW-1:0]        a_idx  [MAX_PROCS];
    logic [TIME_BITS-1:0] a_arr  [MAX_PROCS];
    logic [TIME_BITS-1:0] a_bur  [MAX_PROCS];
    logic                 a_last [MAX_PROCS];

    t_cell_cmd            w_cmd;
    logic [IW-1:0]        w_idx;
    logic                 w_accept;
    logic                 w_hit;
    logic                 w_scan_done;
    logic [TIME_BITS-1:0] w_now_nxt;
    logic [TIME_BITS-1:0] w_tat;
    logic [TIME_BITS-1:0] w_wt;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_hit       = (32'(i_slot) < MAX_PROCS);
    // once the counter reaches MAX_PROCS the last cell holds the winner
    assign w_scan_done = (r_state == ST_SCAN) && (r_cnt == CW'(MAX_PROCS));

    assign w_cmd.load  = w_accept && !i_action && w_hit;
    assign w_cmd.run   = w_scan_done && c_vld[LAST];
    assign w_idx       = w_cmd.run ? c_idx[LAST] : IW'(i_slot);

    // saturating clock
    assign w_now_nxt   = (r_now == '1) ? r_now : r_now + 1'b1;
    assign w_tat       = w_now_nxt - c_arr[LAST];
    assign w_wt        = (w_tat >= c_bur[LAST]) ? w_tat - c_bur[LAST] : '0;

    for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign a_vld[g]  = 1'b0;
            assign a_prio[g] = '0;
            assign a_idx[g]  = '0;
            assign a_arr[g]  = '0;
            assign a_bur[g]  = '0;
            assign a_last[g] = 1'b0;
        end else begin : g_link
            assign a_vld[g]  = c_vld[g-1];
            assign a_prio[g] = c_prio[g-1];
            assign a_idx[g]  = c_idx[g-1];
            assign a_arr[g]  = c_arr[g-1];
            assign a_bur[g]  = c_bur[g-1];
            assign a_last[g] = c_last[g-1];
        end

        pps_cell #(
            .TIME_BITS (TIME_BITS),
            .IW        (IW),
            .CELL_IDX  (g)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_cmd          (w_cmd),
            .i_idx          (w_idx),
            .i_arrival      (TIME_BITS'(i_arrival)),
            .i_burst        (TIME_BITS'(i_burst)),
            .i_prio         (i_prio),
            .i_now          (r_now),
            .i_cand_vld     (a_vld[g]),
            .i_cand_prio    (a_prio[g]),
            .i_cand_idx     (a_idx[g]),
            .i_cand_arrival (a_arr[g]),
            .i_cand_burst   (a_bur[g]),
            .i_cand_last    (a_last[g]),
            .o_cand_vld     (c_vld[g]),
            .o_cand_prio    (c_prio[g]),
            .o_cand_idx     (c_idx[g]),
            .o_cand_arrival (c_arr[g]),
            .o_cand_burst   (c_bur[g]),
            .o_cand_last    (c_last[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_now       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_action) begin
                            r_cnt   <= '0;
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_scan_done) begin
                        r_now   <= w_now_nxt;
                        r_state <= ST_EMIT;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                    end
                end
                ST_EMIT: begin
                    // output register free or being emptied this cycle
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept && !i_action) begin
            r_p_kind <= KIND_LOAD;
            r_p_slot <= '0;
            r_p_fin  <= 1'b0;
            r_p_comp <= '0;
            r_p_tat  <= '0;
            r_p_wt   <= '0;
        end else if (w_scan_done) begin
            if (c_vld[LAST]) begin
                r_p_kind <= KIND_RAN;
                r_p_slot <= SLOT_W'(c_idx[LAST]);
                r_p_fin  <= c_last[LAST];
                r_p_comp <= c_last[LAST] ? FIELD_W'(w_now_nxt) : '0;
                r_p_tat  <= c_last[LAST] ? FIELD_W'(w_tat) : '0;
                r_p_wt   <= c_last[LAST] ? FIELD_W'(w_wt) : '0;
            end else begin
                r_p_kind <= KIND_IDLE;
                r_p_slot <= '0;
                r_p_fin  <= 1'b0;
                r_p_comp <= '0;
                r_p_tat  <= '0;
                r_p_wt   <= '0;
            end
        end
        if ((r_state == ST_EMIT) && (!o_out_valid || i_out_ready)) begin
            o_kind       <= r_p_kind;
            o_ran_slot   <= r_p_slot;
            o_finished   <= r_p_fin;
            o_completion <= r_p_comp;
            o_turnaround <= r_p_tat;
            o_waiting    <= r_p_wt;
        end
    end

endmodule

>>> rtl/pps_checker.sv
module pps_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          i_action,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [1:0]                    o_kind,
    input logic [pps_pkg::SLOT_W-1:0]    o_ran_slot,
    input logic                          o_finished,
    input logic [pps_pkg::FIELD_W-1:0]   o_completion,
    input logic [pps_pkg::FIELD_W-1:0]   o_turnaround,
    input logic [pps_pkg::FIELD_W-1:0]   o_waiting
);
    import pps_pkg::*;

    // a pending result is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    // a tick needs the chain pass, so no new transfer right after it
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_action |=> !o_in_ready)
        else $error("input taken during a tick");

    a_fin_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_finished |-> o_kind == KIND_RAN)
        else $error("finish flagged on a non-run result");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_IDLE || o_kind == KIND_LOAD)
        |-> o_ran_slot == '0 && !o_finished && o_completion == '0)
        else $error("unused fields not zero");

    a_run_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_RAN && !o_finished
        |-> o_completion == '0 && o_turnaround == '0 && o_waiting == '0)
        else $error("timing fields set on an unfinished run");

endmodule

bind preemptive_priority_scheduler_core pps_checker u_pps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_action     (i_action),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_kind       (o_kind),
    .o_ran_slot   (o_ran_slot),
    .o_finished   (o_finished),
    .o_completion (o_completion),
    .o_turnaround (o_turnaround),
    .o_waiting    (o_waiting)
);

>>> dv/pps_schedule_checker.sv
`timescale 1ns / 100ps

module pps_schedule_checker
    import pps_pkg::*;
#(
    parameter int MAX_PROCS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_action,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [FIELD_W-1:0] i_arrival,
    input  logic [FIELD_W-1:0] i_burst,
    input  logic [PRIO_W-1:0]  i_prio,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         i_kind,
    input  logic [SLOT_W-1:0]  i_ran_slot,
    input  logic               i_finished,
    input  logic [FIELD_W-1:0] i_completion,
    input  logic [FIELD_W-1:0] i_turnaround,
    input  logic [FIELD_W-1:0] i_waiting,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_finish_count,
    output int                 o_idle_count
);

    typedef struct packed {
        t_kind              kind;
        logic [SLOT_W-1:0]  ran_slot;
        logic               finished;
        logic [FIELD_W-1:0] completion;
        logic [FIELD_W-1:0] turnaround;
        logic [FIELD_W-1:0] waiting;
    } t_sched_outcome;

    localparam logic [TIME_BITS-1:0] CLOCK_MAX = '1;

    logic                 slot_live   [MAX_PROCS];
    logic [TIME_BITS-1:0] slot_arrive [MAX_PROCS];
    logic [TIME_BITS-1:0] slot_work   [MAX_PROCS];
    logic [TIME_BITS-1:0] slot_left   [MAX_PROCS];
    logic [PRIO_W-1:0]    slot_rank   [MAX_PROCS];
    logic [TIME_BITS-1:0] sched_clock;

    t_sched_outcome predicted_outcomes[$];
    int fails;
    int pending_n;
    int finishes;
    int idles;

    assign o_fail_count   = fails;
    assign o_pending      = pending_n;
    assign o_finish_count = finishes;
    assign o_idle_count   = idles;

    // one scheduler step on the local copy of the slot table
    task automatic schedule_step(input logic act, input logic [SLOT_W-1:0] s,
                                 input logic [FIELD_W-1:0] arr,
                                 input logic [FIELD_W-1:0] bur,
                                 input logic [PRIO_W-1:0] pr,
                                 output t_sched_outcome res);
        int                   pick;
        logic [TIME_BITS-1:0] tat;
        res      = '0;
        res.kind = KIND_LOAD;
        pick     = -1;
        if (!act) begin
            if (int'(s) < MAX_PROCS) begin
                slot_live[s]   = 1'b1;
                slot_arrive[s] = TIME_BITS'(arr);
                slot_work[s]   = TIME_BITS'(bur);
                slot_rank[s]   = pr;
                slot_left[s]   = TIME_BITS'(bur);
            end
            return;
        end
        for (int t = 0; t < MAX_PROCS; t++) begin
            if (slot_live[t] && slot_arrive[t] <= sched_clock && slot_left[t] != '0) begin
                if (pick < 0 || slot_rank[t] < slot_rank[pick])
                    pick = t;
            end
        end
        if (sched_clock != CLOCK_MAX)
            sched_clock = sched_clock + 1'b1;
        if (pick < 0) begin
            res.kind = KIND_IDLE;
            return;
        end
        slot_left[pick] = slot_left[pick] - 1'b1;
        res.kind     = KIND_RAN;
        res.ran_slot = SLOT_W'(pick);
        if (slot_left[pick] == '0) begin
            tat            = sched_clock - slot_arrive[pick];
            res.finished   = 1'b1;
            res.completion = FIELD_W'(sched_clock);
            res.turnaround = FIELD_W'(tat);
            // saturated clock can leave turnaround below the burst
            res.waiting    = (tat >= slot_work[pick]) ? FIELD_W'(tat - slot_work[pick]) : '0;
            slot_live[pick] = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_sched_outcome want;
        t_sched_outcome next_out;
        if (!i_rst_n) begin
            for (int t = 0; t < MAX_PROCS; t++) begin
                slot_live[t]   = 1'b0;
                slot_arrive[t] = '0;
                slot_work[t]   = '0;
                slot_rank[t]   = '0;
                slot_left[t]   = '0;
            end
            sched_clock = '0;
            predicted_outcomes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (predicted_outcomes.size() == 0) begin
                    $error("result transfer with no outstanding item, kind %0d", i_kind);
                    fails++;
                end else begin
                    want = predicted_outcomes.pop_front();
                    check_field("kind", want.kind, i_kind);
                    check_field("ran_slot", want.ran_slot, i_ran_slot);
                    check_field("finished", want.finished, i_finished);
                    check_field("completion", want.completion, i_completion);
                    check_field("turnaround", want.turnaround, i_turnaround);
                    check_field("waiting", want.waiting, i_waiting);
                    if (want.finished)
                        finishes++;
                    if (want.kind == KIND_IDLE)
                        idles++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                schedule_step(i_action, i_slot, i_arrival, i_burst, i_prio, next_out);
                predicted_outcomes.push_back(next_out);
            end
        end
        pending_n = predicted_outcomes.size();
    end

endmodule

>>> dv/tb_preemptive_priority_scheduler_core.sv
`timescale 1ns / 100ps

module tb_preemptive_priority_scheduler_core;
    import pps_pkg::*;

    localparam int MAX_PROCS       = 16;
    localparam int TIME_BITS       = 16;
    localparam int ITEMS_PER_PHASE = 276;   // three random phases, ~850 items
    localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES    = 60;    // idle margin after the last result
    localparam logic [15:0] CLOCK_TOP = 16'hFFFF;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_action;
    logic [SLOT_W-1:0]  i_slot;
    logic [FIELD_W-1:0] i_arrival;
    logic [FIELD_W-1:0] i_burst;
    logic [PRIO_W-1:0]  i_prio;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_kind;
    logic [SLOT_W-1:0]  o_ran_slot;
    logic               o_finished;
    logic [FIELD_W-1:0] o_completion;
    logic [FIELD_W-1:0] o_turnaround;
    logic [FIELD_W-1:0] o_waiting;

    int fail_count;
    int pending;
    int finish_count;
    int idle_count;

    // idling percentages, changed only between phases
    int tx_idle_pct;
    int rx_idle_pct;

    // hold-off request: toggled by stimulus, picked up by the receiver process
    logic hold_req;

    // stimulus-side estimate of the scheduler clock, only used to shape arrivals
    logic [15:0] now_est;
    int          loads_sent;
    int          ticks_sent;

    preemptive_priority_scheduler_core #(
        .MAX_PROCS (MAX_PROCS),
        .TIME_BITS (TIME_BITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_slot       (i_slot),
        .i_arrival    (i_arrival),
        .i_burst      (i_burst),
        .i_prio       (i_prio),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_ran_slot   (o_ran_slot),
        .o_finished   (o_finished),
        .o_completion (o_completion),
        .o_turnaround (o_turnaround),
        .o_waiting    (o_waiting)
    );

    // watches both channels, predicts every result and counts mismatches
    pps_schedule_checker #(
        .MAX_PROCS (MAX_PROCS),
        .TIME_BITS (TIME_BITS)
    ) sched_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_slot         (i_slot),
        .i_arrival      (i_arrival),
        .i_burst        (i_burst),
        .i_prio         (i_prio),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_kind         (o_kind),
        .i_ran_slot     (o_ran_slot),
        .i_finished     (o_finished),
        .i_completion   (o_completion),
        .i_turnaround   (o_turnaround),
        .i_waiting      (o_waiting),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_finish_count (finish_count),
        .o_idle_count   (idle_count)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        int   hold_left;
        logic hold_seen;
        hold_left   = 0;
        hold_seen   = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // offer one item and wait for its transfer; called just after a rising edge
    task automatic send_item(input logic act, input logic [SLOT_W-1:0] s,
                             input logic [FIELD_W-1:0] arr,
                             input logic [FIELD_W-1:0] bur,
                             input logic [PRIO_W-1:0] pr);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_slot     <= s;
        i_arrival  <= arr;
        i_burst    <= bur;
        i_prio     <= pr;
        do
            @(posedge i_clk);
        while (!(i_in_valid && o_in_ready));
        if (act) begin
            ticks_sent++;
            if (now_est != CLOCK_TOP)
                now_est++;
        end else begin
            loads_sent++;
        end
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(1'b1, '0, '0, '0, '0);
    endtask

    // load with random content, arrivals mostly close to the current clock
    task automatic random_load();
        int                 pick;
        logic [FIELD_W-1:0] arr;
        logic [FIELD_W-1:0] bur;
        logic [PRIO_W-1:0]  pr;
        pick = $urandom_range(99);
        if (pick < 60)
            arr = now_est + 16'($urandom_range(8));
        else if (pick < 80)
            arr = '0;
        else
            arr = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 72)
            bur = 16'($urandom_range(6, 1));
        else if (pick < 97)
            bur = 16'($urandom_range(16'hFFFF, 1));
        else
            bur = '0;   // never becomes ready
        // narrow priority range so that ties are common
        pr = ($urandom_range(1) != 0) ? 8'($urandom_range(7)) : 8'($urandom);
        send_item(1'b0, 4'($urandom), arr, bur, pr);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_action    = 1'b0;
        i_slot      = '0;
        i_arrival   = '0;
        i_burst     = '0;
        i_prio      = '0;
        hold_req    = 1'b0;
        tx_idle_pct = 35;
        rx_idle_pct = 58;
        now_est     = '0;
        loads_sent  = 0;
        ticks_sent  = 0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, ties, zero burst, preemption, reload, extremes
        send_ticks(1);                                          // idle on empty table
        send_item(1'b0, 4'd0,  16'd0, 16'd3, 8'd5);
        send_item(1'b0, 4'd1,  16'd0, 16'd2, 8'd5);            // same priority as slot 0
        send_item(1'b0, 4'd15, 16'd0, 16'd0, 8'd0);            // zero burst, never runs
        send_ticks(2);                                          // slot 0 wins the tie
        send_item(1'b0, 4'd2,  16'd0, 16'd1, 8'd0);            // preempts slot 0
        send_ticks(1);                                          // slot 2 finishes at once
        send_item(1'b0, 4'd0,  16'hFFFF, 16'hFFFF, 8'hFF);     // reload part-way through
        send_ticks(3);                                          // slot 1 finishes, then idle
        send_item(1'b0, 4'd3,  16'd4, 16'd2, 8'd255);          // arrival already passed, worst priority
        send_item(1'b0, 4'd7,  16'd0, 16'd1, 8'd0);
        send_item(1'b0, 4'd8,  16'd0, 16'd1, 8'd0);
        send_ticks(5);
        send_item(1'b0, 4'd5,  16'd0, 16'd1, 8'd128);
        send_ticks(2);

        // random phases with changing idling; pressure in the last one
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 35;
                    rx_idle_pct = 58;
                end
                1: begin
                    tx_idle_pct = 58;
                    rx_idle_pct = 35;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    hold_req    = ~hold_req;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(99) < 55)
                    send_ticks(1);
                else
                    random_load();
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d loads and %0d ticks: %0d finishes, %0d idle ticks,",
                 loads_sent, ticks_sent, finish_count, idle_count);
        $display("three back-pressure mixes and one long result stall with the input held off");
        if (fail_count == 0) begin
            $display("PASS preemptive_priority_scheduler_core");
        end else begin
            $display("FAIL preemptive_priority_scheduler_core");
        end
        $finish;
    end

    // watchdog well above the slowest legal run
    initial begin
        #15_000_000;
        $display("FAIL preemptive_priority_scheduler_core");
        $finish;
    end

endmodule

>>> preemptive_priority_scheduler_core.f
rtl/pps_pkg.sv
rtl/pps_cell.sv
rtl/preemptive_priority_scheduler_core.sv
rtl/pps_checker.sv
dv/pps_schedule_checker.sv
dv/tb_preemptive_priority_scheduler_core.sv
